// File: hdl/spq_pkg.sv
package spq_pkg;

	// Defaults for the top level parameters.
	localparam int DEPTH_DEF         = 32;
	localparam int VALUE_BITS_DEF    = 32;
	localparam int PRIORITY_BITS_DEF = 8;

	// Capacity register.
	localparam int               CAP_W     = 6;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// Configuration port geometry.
	localparam int        APB_ADDR_W   = 3;
	localparam int        APB_DATA_W   = 32;
	localparam logic [0:0] REG_CAPACITY = 1'b0;

	// Operation codes carried by func.
	typedef enum logic [1:0] {
		FUNC_ENQ = 2'd0,
		FUNC_DEQ = 2'd1,
		FUNC_CLR = 2'd2,
		FUNC_NOP = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Command broadcast from the control logic to every cell.
	typedef struct packed {
		logic enq;
		logic deq;
		logic clr;
	} cell_cmd_t;

endpackage

// File: hdl/spq_cell.sv
module spq_cell #(
	parameter int VALUE_BITS    = 32,
	parameter int PRIORITY_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spq_pkg::cell_cmd_t              cmd,
	input  logic signed [VALUE_BITS-1:0]    new_value,
	input  logic [PRIORITY_BITS-1:0]        new_prio,
	input  logic                            prev_ge,
	input  logic                            prev_vld,
	input  logic signed [VALUE_BITS-1:0]    prev_value,
	input  logic [PRIORITY_BITS-1:0]        prev_prio,
	input  logic                            next_vld,
	input  logic signed [VALUE_BITS-1:0]    next_value,
	input  logic [PRIORITY_BITS-1:0]        next_prio,
	output logic                            ge,
	output logic                            vld,
	output logic signed [VALUE_BITS-1:0]    value,
	output logic [PRIORITY_BITS-1:0]        prio
);
	import spq_pkg::*;

	logic                         vld_q;
	logic signed [VALUE_BITS-1:0] value_q;
	logic [PRIORITY_BITS-1:0]     prio_q;
	logic                         move;

	// The entry stays in place on an insert when it ranks equal or higher.
	assign ge   = vld_q && (prio_q >= new_prio);
	assign move = cmd.enq && !ge;

	// Occupancy of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.clr) begin
			vld_q <= 1'b0;
		end else if (move) begin
			vld_q <= prev_ge ? 1'b1 : prev_vld;
		end else if (cmd.deq) begin
			vld_q <= next_vld;
		end
	end

	// Stored entry: take the new item, shift back on insert, shift forward on removal.
	always_ff @(posedge clk) begin
		if (move) begin
			if (prev_ge) begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end else begin
				value_q <= prev_value;
				prio_q  <= prev_prio;
			end
		end else if (cmd.deq) begin
			value_q <= next_value;
			prio_q  <= next_prio;
		end
	end

	assign vld   = vld_q;
	assign value = value_q;
	assign prio  = prio_q;

endmodule

// File: hdl/stable_priority_queue.sv
// Channel  Handshake              Payload
// input    in_valid / in_ready    func, value, priority_req
// output   out_valid / out_ready  out_value, out_priority, status, fill_count,
//                                 is_empty, is_full
// config   APB (psel, penable)    paddr, pwdata, prdata; pready tied high
//
// All cells of the chain compare against the incoming priority and shift on the
// same clock edge, so one transfer is taken per cycle while the result register
// is empty or being drained.
// The result is registered and appears in the cycle after the input transfer.
// Reset empties the queue and sets capacity to 32; no clearing pass is needed.
// A stalled result holds the output register and stops input transfers.
module stable_priority_queue #(
	parameter int DEPTH         = spq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
	localparam int CNT_W        = $clog2(DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           func,
	input  logic signed [VALUE_BITS-1:0]         value,
	input  logic [PRIORITY_BITS-1:0]             priority_req,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [VALUE_BITS-1:0]         out_value,
	output logic [PRIORITY_BITS-1:0]             out_priority,
	output logic [1:0]                           status,
	output logic [CNT_W-1:0]                     fill_count,
	output logic                                 is_empty,
	output logic                                 is_full,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [spq_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [spq_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [spq_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);
	import spq_pkg::*;

	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0]               cap_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               count_nxt;
	logic [CMP_W-1:0]               cap_ext;
	logic [CMP_W-1:0]               eff_cap;
	logic                           full_now;
	logic                           full_nxt;
	logic                           accept;
	logic                           reg_sel;
	cell_cmd_t                      cmd;
	status_t                        status_nxt;

	logic                           out_valid_q;
	logic signed [VALUE_BITS-1:0]   out_value_q;
	logic [PRIORITY_BITS-1:0]       out_priority_q;
	status_t                        status_q;
	logic [CNT_W-1:0]               fill_count_q;
	logic                           is_empty_q;
	logic                           is_full_q;

	logic [DEPTH-1:0]                     cell_ge;
	logic [DEPTH-1:0]                     cell_vld;
	logic signed [VALUE_BITS-1:0]         cell_value [DEPTH];
	logic [PRIORITY_BITS-1:0]             cell_prio  [DEPTH];

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
	assign prdata  = reg_sel ? APB_DATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Effective capacity: zero acts as one, values above the depth act as the depth.
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(DEPTH)) begin
			eff_cap = CMP_W'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full_now = (CMP_W'(count_q) >= eff_cap);
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Decode the operation into a cell command, the next count and the status.
	always_comb begin
		cmd        = '0;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		case (func)
			FUNC_ENQ: begin
				if (full_now) begin
					status_nxt = ST_FULL;
				end else begin
					cmd.enq   = accept;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			FUNC_DEQ: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					cmd.deq   = accept;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			FUNC_CLR: begin
				cmd.clr   = accept;
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	assign full_nxt = (CMP_W'(count_nxt) >= eff_cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	// Chain of cells, head at index zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                         p_ge;
		logic                         p_vld;
		logic signed [VALUE_BITS-1:0] p_value;
		logic [PRIORITY_BITS-1:0]     p_prio;
		logic                         n_vld;
		logic signed [VALUE_BITS-1:0] n_value;
		logic [PRIORITY_BITS-1:0]     n_prio;

		if (i == 0) begin : g_head
			assign p_ge    = 1'b1;
			assign p_vld   = 1'b0;
			assign p_value = '0;
			assign p_prio  = '0;
		end else begin : g_body
			assign p_ge    = cell_ge[i-1];
			assign p_vld   = cell_vld[i-1];
			assign p_value = cell_value[i-1];
			assign p_prio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_vld   = 1'b0;
			assign n_value = '0;
			assign n_prio  = '0;
		end else begin : g_inner
			assign n_vld   = cell_vld[i+1];
			assign n_value = cell_value[i+1];
			assign n_prio  = cell_prio[i+1];
		end

		spq_cell #(
			.VALUE_BITS    (VALUE_BITS),
			.PRIORITY_BITS (PRIORITY_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_value  (value),
			.new_prio   (priority_req),
			.prev_ge    (p_ge),
			.prev_vld   (p_vld),
			.prev_value (p_value),
			.prev_prio  (p_prio),
			.next_vld   (n_vld),
			.next_value (n_value),
			.next_prio  (n_prio),
			.ge         (cell_ge[i]),
			.vld        (cell_vld[i]),
			.value      (cell_value[i]),
			.prio       (cell_prio[i])
		);
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; the head entry is captured before the chain shifts.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (cmd.deq) begin
				out_value_q    <= cell_value[0];
				out_priority_q <= cell_prio[0];
			end else begin
				out_value_q    <= '0;
				out_priority_q <= '0;
			end
			status_q     <= status_nxt;
			fill_count_q <= count_nxt;
			is_empty_q   <= (count_nxt == '0);
			is_full_q    <= full_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_priority = out_priority_q;
	assign status       = status_q;
	assign fill_count   = fill_count_q;
	assign is_empty     = is_empty_q;
	assign is_full      = is_full_q;

	// The occupied cells always match the count.
	a_vld_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_vld) == 32'(count_q))
		else $error("occupied cells differ from count");

	// The count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("count above depth");

	// A clear transfer empties the chain.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_CLR) |=> (count_q == '0 && cell_vld == '0))
		else $error("clear did not empty the queue");

	// A removal on an empty queue reports an empty queue.
	a_empty_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_EMPTY) |-> (fill_count_q == '0 && is_empty_q))
		else $error("empty error with entries held");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;

	import spq_pkg::*;

	localparam int VW    = VALUE_BITS_DEF;
	localparam int PW    = PRIORITY_BITS_DEF;
	localparam int DEPTH = DEPTH_DEF;
	localparam int CNT_W = $clog2(DEPTH_DEF + 1);
	localparam int AW    = APB_ADDR_W;
	localparam int DW    = APB_DATA_W;

	// Register addresses: capacity at its index, and one unmapped address past it.
	localparam logic [AW-1:0] CAPACITY_ADDR = AW'(4 * REG_CAPACITY);
	localparam logic [AW-1:0] UNMAPPED_ADDR = AW'(4 * (REG_CAPACITY + 1));

	localparam int WATCHDOG_LIMIT      = 3000;
	localparam int BACKPRESSURE_CYCLES = 300;
	localparam int RANDOM_SEGMENT_OPS  = 115;

	// One result as the queue should report it.
	typedef struct packed {
		logic signed [VW-1:0] val;
		logic [PW-1:0]        pri;
		status_t              st;
		logic [CNT_W-1:0]     cnt;
		logic                 empty;
		logic                 full;
	} outcome_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [1:0]           func         = FUNC_NOP;
	logic signed [VW-1:0] value        = '0;
	logic [PW-1:0]        priority_req = '0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic signed [VW-1:0] out_value;
	logic [PW-1:0]        out_priority;
	logic [1:0]           status;
	logic [CNT_W-1:0]     fill_count;
	logic                 is_empty;
	logic                 is_full;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [AW-1:0]        paddr        = '0;
	logic [DW-1:0]        pwdata       = '0;
	logic [DW-1:0]        prdata;
	logic                 pready;

	// Shadow of the queue contents, sorted with the head at index 0.
	logic signed [VW-1:0] shadow_values[$];
	logic [PW-1:0]        shadow_priorities[$];
	logic [CAP_W-1:0]     shadow_capacity = CAP_RESET;

	outcome_t awaited_outcomes[$];
	outcome_t arrived;

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_cnt      = 0;
	int stall_until    = 0;
	int quiet_cycles   = 0;

	stable_priority_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.value       (value),
		.priority_req(priority_req),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.out_priority(out_priority),
		.status      (status),
		.fill_count  (fill_count),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Capacity as the queue applies it: zero acts as one, anything above the depth as the depth.
	function automatic int usable_capacity();
		if (shadow_capacity == 0) begin
			return 1;
		end
		if (shadow_capacity > DEPTH) begin
			return DEPTH;
		end
		return shadow_capacity;
	endfunction

	// Applies one operation to the shadow queue and returns the result it should produce.
	function automatic outcome_t expected_outcome(input func_t op, input logic signed [VW-1:0] v,
			input logic [PW-1:0] p);
		outcome_t r;
		int       limit;
		int       pos;
		r = '0;
		r.st = ST_OK;
		limit = usable_capacity();
		case (op)
			FUNC_ENQ: begin
				if (shadow_priorities.size() >= limit) begin
					r.st = ST_FULL;
				end else begin
					// The new entry goes behind every entry of equal or higher priority.
					pos = shadow_priorities.size();
					for (int i = 0; i < shadow_priorities.size(); i++) begin
						if (shadow_priorities[i] < p) begin
							pos = i;
							break;
						end
					end
					shadow_values.insert(pos, v);
					shadow_priorities.insert(pos, p);
				end
			end
			FUNC_DEQ: begin
				if (shadow_priorities.size() == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.val = shadow_values.pop_front();
					r.pri = shadow_priorities.pop_front();
				end
			end
			FUNC_CLR: begin
				shadow_values.delete();
				shadow_priorities.delete();
			end
			default: begin
			end
		endcase
		r.cnt = CNT_W'(shadow_priorities.size());
		r.empty = (shadow_priorities.size() == 0);
		r.full = (shadow_priorities.size() >= limit);
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Result side: checks every transfer against the oldest expectation, then
	// decides whether to accept on the next edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: unexpected result, actual value %0h priority %0h status %0h count %0d",
					$time, out_value, out_priority, status, fill_count);
				mismatch_count++;
			end else begin
				arrived = awaited_outcomes.pop_front();
				compare_field("out_value", arrived.val, out_value);
				compare_field("out_priority", arrived.pri, out_priority);
				compare_field("status", arrived.st, status);
				compare_field("fill_count", arrived.cnt, fill_count);
				compare_field("is_empty", arrived.empty, is_empty);
				compare_field("is_full", arrived.full, is_full);
			end
		end
		if (cycle_cnt < stall_until) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Ends the run when nothing has moved on any port for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one operation, with a random gap first, and records its outcome on transfer.
	task automatic send_op(input func_t op, input logic signed [VW-1:0] v, input logic [PW-1:0] p);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func <= op;
		value <= v;
		priority_req <= p;
		do begin
			@(posedge clk);
		end while (!in_ready);
		awaited_outcomes.push_back(expected_outcome(op, v, p));
	endtask

	// Stops offering and waits until every outstanding result has been taken.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(input logic [AW-1:0] addr, input logic [DW-1:0] data);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == CAPACITY_ADDR) begin
			shadow_capacity = data[CAP_W-1:0];
		end
	endtask

	task automatic apb_read_capacity();
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAPACITY_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		compare_field("prdata", DW'(shadow_capacity), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mostly a few low priorities so that ties are common, sometimes the extremes
	// or any value.
	function automatic logic [PW-1:0] pick_priority();
		case ($urandom_range(3))
			0: return PW'($urandom_range(255));
			1: return $urandom_range(1) ? '1 : '0;
			default: return PW'($urandom_range(3));
		endcase
	endfunction

	task automatic test_reset_state();
		apb_read_capacity();
		send_op(FUNC_DEQ, '0, '0);
		send_op(FUNC_NOP, $urandom, pick_priority());
		send_op(FUNC_CLR, '0, '0);
	endtask

	// Ties must leave in arrival order; extremes of value and priority.
	task automatic test_sort_order();
		send_op(FUNC_ENQ, 32'sh7fffffff, 8'd0);
		send_op(FUNC_ENQ, 32'sh80000000, 8'd255);
		send_op(FUNC_ENQ, 32'sd0, 8'd128);
		send_op(FUNC_ENQ, -32'sd1, 8'd128);
		send_op(FUNC_ENQ, 32'sh55aa55aa, 8'd255);
		send_op(FUNC_ENQ, 32'sh2aaa5555, 8'd0);
		repeat (6) send_op(FUNC_DEQ, $urandom, pick_priority());
		send_op(FUNC_DEQ, '1, '1);
	endtask

	// Full rejection, capacity lowered below the count, capacity zero and an
	// unmapped register write.
	task automatic test_capacity_limits();
		apb_write(CAPACITY_ADDR, 2);
		repeat (3) send_op(FUNC_ENQ, $urandom, 8'd5);
		apb_write(CAPACITY_ADDR, 1);
		send_op(FUNC_ENQ, $urandom, 8'd9);
		send_op(FUNC_DEQ, '0, '0);
		apb_write(CAPACITY_ADDR, 0);
		send_op(FUNC_ENQ, $urandom, 8'd200);
		apb_write(UNMAPPED_ADDR, 5);
		apb_read_capacity();
		send_op(FUNC_CLR, '0, '0);
		send_op(FUNC_ENQ, $urandom, 8'd1);
		send_op(FUNC_CLR, '0, '0);
		apb_write(CAPACITY_ADDR, 63);
		apb_read_capacity();
	endtask

	// Capacity above the depth: fill every cell, overflow once, then empty it.
	task automatic test_full_depth();
		apb_write(CAPACITY_ADDR, 63);
		repeat (DEPTH + 1) send_op(FUNC_ENQ, $urandom, pick_priority());
		repeat (DEPTH + 1) send_op(FUNC_DEQ, $urandom, pick_priority());
	endtask

	// The result side holds off for a long stretch while operations keep coming.
	task automatic test_backpressure();
		apb_write(CAPACITY_ADDR, CAP_RESET);
		send_idle_pct = 0;
		stall_until <= cycle_cnt + BACKPRESSURE_CYCLES;
		repeat (40) begin
			send_op($urandom_range(2) != 0 ? FUNC_ENQ : FUNC_DEQ, $urandom, pick_priority());
		end
	endtask

	// Bursts that lean toward filling or draining, with rare clears and no-ops.
	task automatic run_random_ops(input int n_ops);
		int    fill_bias;
		int    roll;
		func_t op;
		fill_bias = 50;
		for (int k = 0; k < n_ops; k++) begin
			if (k % 24 == 0) begin
				fill_bias = $urandom_range(1) ? 75 : 25;
			end
			roll = $urandom_range(99);
			if (roll < 2) begin
				op = FUNC_CLR;
			end else if (roll < 4) begin
				op = FUNC_NOP;
			end else begin
				op = ($urandom_range(99) < fill_bias) ? FUNC_ENQ : FUNC_DEQ;
			end
			send_op(op, $urandom, pick_priority());
		end
	endtask

	// Random traffic over each idle profile and a spread of capacities.
	task automatic test_random_traffic();
		int send_profile[4]  = '{0, 66, 0, 38};
		int recv_profile[4]  = '{0, 0, 66, 38};
		int capacity_list[8] = '{32, 1, 0, 5, 63, 17, 2, 32};
		for (int seg = 0; seg < 8; seg++) begin
			apb_write(CAPACITY_ADDR, capacity_list[seg]);
			send_idle_pct = send_profile[seg % 4];
			recv_stall_pct <= recv_profile[seg % 4];
			run_random_ops(RANDOM_SEGMENT_OPS);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_sort_order();
		test_capacity_limits();
		test_full_depth();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
